### hw/rtl/fixed_pattern_line_matcher_unit_assert.svh
// Assertion macros for the fixed pattern line matcher.
// Included by the top level; the checks drop out when SYNTH is defined.
`ifndef FIXED_PATTERN_LINE_MATCHER_UNIT_ASSERT_SVH
`define FIXED_PATTERN_LINE_MATCHER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication under reset.
`define FPLM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication under reset.
`define FPLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FPLM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FPLM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/fplm_pkg.sv
// Shared constants, types and helper functions of the fixed pattern line matcher.
// No dependencies.
`default_nettype none
package fplm_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int COUNT_WIDTH = 32;

    localparam int IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int FILL_W  = $clog2(MAX_PATTERN + 1);
    localparam int LEN_W   = 4;
    localparam int PAT_W   = 64;
    localparam int OUT_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] NEWLINE = 8'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_MATCHES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_TOTAL   = 2'd3;

    localparam logic KIND_OCCURRENCE = 1'b0;
    localparam logic KIND_TOTAL      = 1'b1;

    typedef struct packed {
        logic [PAT_W-1:0] pattern_bytes;
        logic [LEN_W-1:0] pattern_length;
        logic             report_matches;
        logic             report_total;
    } t_cfg;

    typedef struct packed {
        logic             kind;
        logic [OUT_W-1:0] line_number;
        logic [OUT_W-1:0] match_count;
        logic             first_on_line;
        logic             last;
    } t_result;

    // Up to two results per beat, slot 0 first.
    typedef struct packed {
        logic [1:0] num;
        t_result    r1;
        t_result    r0;
    } t_push;

    function automatic logic [OUT_W-1:0] sat_out(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return (wide > 64'(32'hFFFF_FFFF)) ? {OUT_W{1'b1}} : wide[OUT_W-1:0];
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/fplm_matcher.sv
// Byte window, pattern compare, line and occurrence counters.
// Depends on fplm_pkg; produces up to two results per accepted beat.
`default_nettype none
module fplm_matcher
    import fplm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_beat,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_file,
    output t_push           o_push
);

    logic [7:0]             r_win [MAX_PATTERN];
    logic [7:0]             n_win [MAX_PATTERN];
    logic [FILL_W-1:0]      r_fill, n_fill, fill_inc;
    logic [COUNT_WIDTH-1:0] r_line, n_line;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_has_match, n_has_match;
    logic [LEN_W-1:0]       len;
    logic [IDX_W-1:0]       len_m1;
    logic [MAX_PATTERN-1:0] cand;
    logic                   hit, rep_occ, rep_tot;
    t_result                occ, tot;

    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            len = LEN_W'(1);
        end else if (i_cfg.pattern_length > LEN_W'(MAX_PATTERN)) begin
            len = LEN_W'(MAX_PATTERN);
        end else begin
            len = i_cfg.pattern_length;
        end
        len_m1 = IDX_W'(len - 1'b1);
    end

    // Shift the new byte in; entry 0 holds the newest.
    always_comb begin
        n_win[0] = i_data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    assign fill_inc = (r_fill < FILL_W'(MAX_PATTERN)) ? r_fill + 1'b1 : r_fill;

    // One candidate compare per pattern length; the active length picks one.
    always_comb begin
        for (int l = 1; l <= MAX_PATTERN; l++) begin
            cand[l-1] = 1'b1;
            for (int j = 0; j < l; j++) begin
                if (n_win[j] != i_cfg.pattern_bytes[8*(l-1-j) +: 8]) begin
                    cand[l-1] = 1'b0;
                end
            end
        end
        hit = (LEN_W'(fill_inc) >= len) && cand[len_m1];
    end

    always_comb begin
        n_count     = hit ? sat_inc(r_count) : r_count;
        n_fill      = hit ? '0 : fill_inc;
        n_line      = r_line;
        n_has_match = r_has_match | hit;
        if (i_data_byte == NEWLINE) begin
            n_line      = sat_inc(r_line);
            n_has_match = 1'b0;
        end

        rep_occ = hit & i_cfg.report_matches;
        rep_tot = i_end_of_file & i_cfg.report_total;

        occ.kind          = KIND_OCCURRENCE;
        occ.line_number   = sat_out(r_line);
        occ.match_count   = sat_out(n_count);
        occ.first_on_line = ~r_has_match;
        occ.last          = ~rep_tot;

        tot.kind          = KIND_TOTAL;
        tot.line_number   = sat_out(r_line);
        tot.match_count   = sat_out(n_count);
        tot.first_on_line = 1'b0;
        tot.last          = 1'b1;

        o_push.num = i_beat ? (2'(rep_occ) + 2'(rep_tot)) : 2'd0;
        o_push.r0  = rep_occ ? occ : tot;
        o_push.r1  = tot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_line      <= COUNT_WIDTH'(1);
            r_count     <= '0;
            r_has_match <= 1'b0;
        end else if (i_beat) begin
            if (i_end_of_file) begin
                r_fill      <= '0;
                r_line      <= COUNT_WIDTH'(1);
                r_count     <= '0;
                r_has_match <= 1'b0;
            end else begin
                r_fill      <= n_fill;
                r_line      <= n_line;
                r_count     <= n_count;
                r_has_match <= n_has_match;
            end
        end
    end

    // Window bytes are guarded by the fill count and need no reset.
    always_ff @(posedge i_clk) begin
        if (i_beat) begin
            r_win <= n_win;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/fplm_result_fifo.sv
// Four-entry result queue: takes up to two results a cycle, hands out one.
// Depends on fplm_pkg.
`default_nettype none
module fplm_result_fifo
    import fplm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_push i_push,
    output logic      o_room,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_result   o_result
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr, r_rd;
    logic [FIFO_CNT_W-1:0]  r_cnt;
    logic                   pop;

    assign o_valid  = (r_cnt != '0);
    assign o_room   = (r_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign pop      = o_valid & i_ready;
    assign o_result = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_PTR_W'(i_push.num);
            r_rd  <= r_rd + FIFO_PTR_W'(pop);
            r_cnt <= r_cnt + FIFO_CNT_W'(i_push.num) - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr + 1'b1] <= i_push.r1;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/fixed_pattern_line_matcher_unit.sv
// Fixed pattern line matcher: one input beat per cycle; results are queued on accept.
// Throughput is one byte per cycle while the queue has room; output is bound to one
// result beat per cycle, set by the single read port of the four-entry result queue.
// Synchronous active-low reset restores the configuration defaults and file state.
// Depends on fplm_pkg, fplm_matcher, fplm_result_fifo and the assertion header.
`default_nettype none
`include "fixed_pattern_line_matcher_unit_assert.svh"
module fixed_pattern_line_matcher_unit
    import fplm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write port
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic                   s_axis_tlast,   // end_of_file
    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [31:0] line_number,
                                                        // [63:32] match_count,
                                                        // [64] first_on_line, rest zero
    output logic                        m_axis_tuser,   // result_kind
    output logic                        m_axis_tlast    // last_result
);

    t_cfg    r_cfg;
    t_push   w_push;
    t_result w_res;
    logic    w_room;
    logic    w_beat;

    // Configuration registers; a write takes effect from the next accepted beat.
    // Write them only while no byte is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_bytes  <= '0;
            r_cfg.pattern_length <= LEN_W'(1);
            r_cfg.report_matches <= 1'b1;
            r_cfg.report_total   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_BYTES:  r_cfg.pattern_bytes  <= i_cfg_data[PAT_W-1:0];
                CFG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg_data[LEN_W-1:0];
                CFG_REPORT_MATCHES: r_cfg.report_matches <= i_cfg_data[0];
                CFG_REPORT_TOTAL:   r_cfg.report_total   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Accept a beat whenever the queue has room for two results, so a byte that
    // both completes a match and ends the file never overflows it.
    assign s_axis_tready = w_room;
    assign w_beat        = s_axis_tvalid & s_axis_tready;

    // Compare the window and update counters in the accept cycle.
    fplm_matcher u_matcher (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_beat        (w_beat),
        .i_data_byte   (s_axis_tdata[7:0]),
        .i_end_of_file (s_axis_tlast),
        .o_push        (w_push)
    );

    // Hold results until the sink takes them; the queue parts the two sides.
    fplm_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_room   (w_room),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_res)
    );

    assign m_axis_tdata = {7'd0, w_res.first_on_line, w_res.match_count, w_res.line_number};
    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;

    // A stalled input side means results are waiting.
    `FPLM_ASSERT_IMPL(a_stall_has_results, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid)
    // An end-of-file beat with totals enabled always yields a result beat next.
    `FPLM_ASSERT_NEXT(a_total_emitted, i_clk, i_rst_n, w_beat && s_axis_tlast && r_cfg.report_total, m_axis_tvalid)
    // Never push results without an accepted beat.
    `FPLM_ASSERT_IMPL(a_push_needs_beat, i_clk, i_rst_n, w_push.num != 2'd0, w_beat)

endmodule
`default_nettype wire

### sim/fplm_tb_pkg.sv
`timescale 1ns / 1ps
// Occurrence scoreboard for the fixed pattern line matcher testbench.
// Predicts result beats from accepted input bytes; depends on fplm_pkg.
package fplm_tb_pkg;
    import fplm_pkg::*;

    class occurrence_scoreboard;
        // register copies
        logic [PAT_W-1:0]       pat_bytes;
        logic [LEN_W-1:0]       pat_len;
        logic                   want_hits;
        logic                   want_total;
        // file state
        logic [7:0]             window [8];
        int                     fill;
        logic [COUNT_WIDTH-1:0] line_no;
        logic [COUNT_WIDTH-1:0] hit_count;
        logic                   line_hit;
        t_result                pending_results [$];
        int unsigned            mismatches;
        int unsigned            bytes_seen;
        int unsigned            files_seen;
        int unsigned            hits_seen;
        int unsigned            totals_seen;

        function new();
            pat_bytes   = '0;
            pat_len     = LEN_W'(1);
            want_hits   = 1'b1;
            want_total  = 1'b0;
            mismatches  = 0;
            bytes_seen  = 0;
            files_seen  = 0;
            hits_seen   = 0;
            totals_seen = 0;
            clear_file();
        endfunction

        function void clear_file();
            foreach (window[i]) window[i] = 8'h00;
            fill      = 0;
            line_no   = COUNT_WIDTH'(1);
            hit_count = '0;
            line_hit  = 1'b0;
        endfunction

        function logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PATTERN_BYTES:  pat_bytes  = data[PAT_W-1:0];
                CFG_PATTERN_LENGTH: pat_len    = data[LEN_W-1:0];
                CFG_REPORT_MATCHES: want_hits  = data[0];
                CFG_REPORT_TOTAL:   want_total = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // Shift one byte in and queue the result beats it causes.
        function void note_byte(input logic [7:0] b, input logic eof);
            int      len;
            int      k;
            logic    hit;
            t_result r;
            t_result caused [$];
            len = (pat_len == 0) ? 1 : ((pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len));
            for (k = 7; k > 0; k--) window[k] = window[k-1];
            window[0] = b;
            if (fill < MAX_PATTERN) fill++;
            hit = (fill >= len);
            for (k = 0; k < len; k++)
                if (window[len-1-k] != pat_bytes[8*k +: 8]) hit = 1'b0;
            if (hit) begin
                hit_count = bump(hit_count);
                if (want_hits) begin
                    r.kind          = KIND_OCCURRENCE;
                    r.line_number   = OUT_W'(line_no);
                    r.match_count   = OUT_W'(hit_count);
                    r.first_on_line = !line_hit;
                    r.last          = 1'b0;
                    caused.push_back(r);
                end
                line_hit = 1'b1;
                fill     = 0;
            end
            if (eof && want_total) begin
                r.kind          = KIND_TOTAL;
                r.line_number   = OUT_W'(line_no);
                r.match_count   = OUT_W'(hit_count);
                r.first_on_line = 1'b0;
                r.last          = 1'b0;
                caused.push_back(r);
            end
            // newline advances the line only after this byte's compare
            if (b == NEWLINE) begin
                line_no  = bump(line_no);
                line_hit = 1'b0;
            end
            if (eof) begin
                clear_file();
                files_seen++;
            end
            if (caused.size() > 0) caused[caused.size()-1].last = 1'b1;
            foreach (caused[i]) pending_results.push_back(caused[i]);
            bytes_seen++;
        endfunction

        function void check_result(input logic kind, input logic [OUT_W-1:0] line,
                                   input logic [OUT_W-1:0] count, input logic first,
                                   input logic last);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d line %0d count %0d", kind, line, count);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (want.kind !== kind) begin
                $error("result_kind: expected %0d, got %0d", want.kind, kind);
                mismatches++;
            end
            if (want.line_number !== line) begin
                $error("line_number: expected %0d, got %0d", want.line_number, line);
                mismatches++;
            end
            if (want.match_count !== count) begin
                $error("match_count: expected %0d, got %0d", want.match_count, count);
                mismatches++;
            end
            if (want.first_on_line !== first) begin
                $error("first_on_line: expected %0d, got %0d", want.first_on_line, first);
                mismatches++;
            end
            if (want.last !== last) begin
                $error("last_result: expected %0d, got %0d", want.last, last);
                mismatches++;
            end
            if (want.kind == KIND_TOTAL) totals_seen++;
            else hits_seen++;
        endfunction
    endclass

endpackage

### sim/tb_fixed_pattern_line_matcher_unit.sv
`timescale 1ns / 1ps
// Testbench for fixed_pattern_line_matcher_unit: directed files, then random files
// under several register settings, checked beat by beat. Depends on fplm_pkg, fplm_tb_pkg.
module tb_fixed_pattern_line_matcher_unit;
    import fplm_pkg::*;
    import fplm_tb_pkg::*;

    localparam int unsigned DRAIN_GAP     = 8;     // cycles after drain before a register write
    localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no beat on either side
    localparam int unsigned HOLD_AFTER    = 100;   // input bytes before the long output stall
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS   = 105;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } t_file_byte;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic                   s_axis_tlast  = 1'b0; // end_of_file
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [31:0] line_number, [63:32] match_count,
                                                  // [64] first_on_line
    logic                   m_axis_tuser;         // result_kind
    logic                   m_axis_tlast;         // last_result

    occurrence_scoreboard sb = new();

    t_file_byte  file_bytes [$];   // bytes waiting to be offered
    t_file_byte  tx_beat;
    int unsigned bytes_queued = 0;
    int unsigned burst_left   = 0;
    int unsigned gap_left     = 0;
    int unsigned rx_cycle     = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;
    int unsigned quiet_cycles = 0;

    fixed_pattern_line_matcher_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sender: offer queued bytes in bursts of random length, with random gaps
    // between bursts. Hold a beat until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (file_bytes.size() > 0) begin
                tx_beat = file_bytes.pop_front();
                s_axis_tdata  <= tx_beat.data;
                s_axis_tlast  <= tx_beat.eof;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // start a new burst; about a third of bursts follow with no gap
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: cycle through ready patterns of its own; once, early in the
    // first random phase where every byte can yield results, drop ready for a
    // long stretch so the result queue fills and the input side stalls while
    // the sender keeps offering.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (!hold_done && sb.bytes_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case ((rx_cycle / 97) % 4)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_axis_tready <= (rx_cycle % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    // Monitor: check result beats against the oldest prediction, and predict
    // from each accepted input beat. A byte's results cannot leave in the
    // cycle it is taken, so the order of the two calls does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata[OUT_W-1:0],
                                m_axis_tdata[2*OUT_W-1:OUT_W], m_axis_tdata[2*OUT_W],
                                m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic eof);
        t_file_byte fb;
        fb.data = b;
        fb.eof  = eof;
        file_bytes.push_back(fb);
        bytes_queued++;
    endtask

    // Wait until every queued byte is taken and every predicted result has
    // left, then let zero-result bytes still in flight clear the pipeline.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (sb.bytes_seen != bytes_queued || sb.pending() != 0);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Write all four registers; bits above each register's width carry junk.
    task automatic write_config(input logic [63:0] pat, input logic [3:0] len,
                                input logic hits, input logic total);
        logic [CFG_DATA_W-1:0] junk;
        write_reg(CFG_PATTERN_BYTES, pat);
        junk = {$urandom, $urandom};
        write_reg(CFG_PATTERN_LENGTH, {junk[CFG_DATA_W-1:LEN_W], len});
        junk = {$urandom, $urandom};
        write_reg(CFG_REPORT_MATCHES, {junk[CFG_DATA_W-1:1], hits});
        junk = {$urandom, $urandom};
        write_reg(CFG_REPORT_TOTAL, {junk[CFG_DATA_W-1:1], total});
    endtask

    // Build one file of at least flen bytes: mostly whole occurrences, broken
    // prefixes, newlines and pattern bytes, with some noise. Leave off the
    // end-of-file mark when open_end is set so the file runs into the next phase.
    task automatic queue_file(input logic [63:0] pat, input int unsigned plen,
                              input int unsigned flen, input bit open_end,
                              inout int unsigned queued);
        logic [7:0]  body [$];
        int unsigned pick;
        int unsigned cut;
        int unsigned pos;
        int unsigned n;
        while (body.size() < flen) begin
            pick = $urandom_range(0, 99);
            if (pick < 24) begin
                for (n = 0; n < plen; n++) body.push_back(pat[8*n +: 8]);
            end else if (pick < 34 && plen > 1) begin
                cut = $urandom_range(1, plen - 1);
                for (n = 0; n < cut; n++) body.push_back(pat[8*n +: 8]);
            end else if (pick < 46) begin
                body.push_back(NEWLINE);
            end else if (pick < 66) begin
                body.push_back(8'($urandom_range(0, 255)));
            end else begin
                pos = $urandom_range(0, plen - 1);
                body.push_back(pat[8*pos +: 8]);
            end
        end
        for (n = 0; n < body.size(); n++)
            push_byte(body[n], !open_end && (n == body.size() - 1));
        queued += body.size();
    endtask

    initial begin : main_seq
        int unsigned phase;
        int unsigned queued;
        int unsigned flen;
        int unsigned plen;
        int unsigned n;
        logic [63:0] pat;
        logic [3:0]  len;
        logic        hits;
        logic        total;
        logic [7:0]  pb;
        int unsigned leftover;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: pattern 0x00 of length 1, occurrences only.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(NEWLINE, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_drained();

        // Newline inside the pattern, junk in unused pattern bytes, totals on.
        write_config(64'hC3A5_5A3C_96E1_0A61, 4'd2, 1'b1, 1'b1);
        push_byte(8'h61, 1'b0);
        push_byte(NEWLINE, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(NEWLINE, 1'b0);
        push_byte(8'h78, 1'b1);
        wait_drained();

        // Length code zero acts as one; two hits on one line.
        write_config(64'h1122_3344_5566_777A, 4'd0, 1'b1, 1'b1);
        push_byte(8'h7A, 1'b0);
        push_byte(8'h7A, 1'b0);
        push_byte(NEWLINE, 1'b0);
        push_byte(8'h7A, 1'b1);
        wait_drained();

        // Length code above the maximum acts as eight.
        write_config(64'h0807_0605_0403_0201, 4'd15, 1'b1, 1'b1);
        for (n = 1; n <= 8; n++) push_byte(8'(n), n == 8);
        wait_drained();

        // Non-overlapping hits counted while occurrence reports are off.
        write_config(64'h5A5A_5A5A_5A5A_6161, 4'd2, 1'b0, 1'b1);
        for (n = 0; n < 5; n++) push_byte(8'h61, n == 4);
        wait_drained();

        // Random part: one register setting per phase, extremes first.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       len = 4'd1;
                1:       len = 4'd15;
                2:       len = 4'd8;
                3:       len = 4'd0;
                default: len = 4'($urandom_range(0, 15));
            endcase
            plen = (len == 0) ? 1 : ((len > MAX_PATTERN) ? MAX_PATTERN : len);
            // every third phase uses one repeated byte to stress non-overlap
            pb = 8'($urandom_range(0, 255));
            for (n = 0; n < 8; n++) begin
                if (phase % 3 != 2) begin
                    pb = ($urandom_range(0, 99) < 15) ? NEWLINE : 8'($urandom_range(0, 255));
                end
                pat[8*n +: 8] = pb;
            end
            case (phase)
                0:       begin hits = 1'b1; total = 1'b1; end
                1:       begin hits = 1'b0; total = 1'b1; end
                2:       begin hits = 1'b1; total = 1'b0; end
                3:       begin hits = 1'b0; total = 1'b0; end
                default: begin hits = ($urandom_range(0, 3) != 0); total = $urandom_range(0, 1); end
            endcase
            write_config(pat, len, hits, total);

            queued = 0;
            while (queued < PHASE_ITEMS) begin
                flen = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 48);
                queue_file(pat, plen, flen,
                           (queued + flen >= PHASE_ITEMS) && ($urandom_range(0, 2) == 0),
                           queued);
            end
            wait_drained();
        end

        // Drain and count predictions that never arrived.
        wait_drained();
        leftover = sb.pending();
        if (leftover != 0)
            $error("%0d expected results never arrived", leftover);

        $display("Checked %0d bytes in %0d files: %0d occurrence and %0d total results.",
                 sb.bytes_seen, sb.files_seen, sb.hits_seen, sb.totals_seen);
        $display("Covered %0d register settings; long output stall applied: %0d.",
                 RANDOM_PHASES + 5, hold_done);
        if (sb.mismatches == 0 && leftover == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
